/* hdl/rtpp_pkg.sv */
// Shared types, constants and tables for the rotating target plate block.
`default_nettype none
package rtpp_pkg;

  localparam int MAX_PLATES   = 8;
  localparam int POS_W        = 24;
  localparam int ANG_W        = 16;
  localparam int RAD_W        = 22;
  localparam int TRIG_W       = 16;
  localparam int CNT_W        = 4;
  localparam int IDX_W        = 3;
  localparam int CORDIC_STEPS = 20;
  localparam int CW           = 28;  // CORDIC datapath width, Q24 scale

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(4);
  localparam logic [CNT_W-1:0] COUNT_MAX   = CNT_W'(MAX_PLATES);
  localparam logic [CNT_W-1:0] COUNT_ALT   = CNT_W'(4);

  localparam logic signed [17:0] PI_Q13      = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
  localparam logic signed [17:0] WRAP_TWICE  = 18'sd77208;
  localparam logic signed [17:0] FOUR_PI_Q13 = 18'sd102944;

  localparam logic signed [CW-1:0] PI_Q24      = 28'sd52707179;
  localparam logic signed [CW-1:0] HALF_PI_Q24 = 28'sd26353589;
  localparam logic signed [CW-1:0] GAIN_Q24    = 28'sd10188014;

  localparam logic signed [CW-1:0] ATAN_Q24 [CORDIC_STEPS] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
    28'sd524117, 28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768,
    28'sd16384, 28'sd8192, 28'sd4096, 28'sd2048, 28'sd1024,
    28'sd512, 28'sd256, 28'sd128, 28'sd64, 28'sd32
  };

  typedef struct packed {
    logic signed [POS_W-1:0] cx;
    logic signed [POS_W-1:0] cy;
    logic signed [POS_W-1:0] z;
    logic signed [ANG_W-1:0] angle;
    logic signed [RAD_W-1:0] r;
    logic [IDX_W-1:0]        idx;
    logic                    alt;
    logic                    last;
  } plate_job_t;

  // rounded plate spacing i*2pi/n in Q3.13
  function automatic logic [15:0] plate_step(input logic [CNT_W-1:0] n,
                                             input logic [IDX_W-1:0] i);
    logic [15:0] v;
    v = 16'd0;
    case ({n, i})
      {4'd2, 3'd1}: v = 16'd25736;
      {4'd3, 3'd1}: v = 16'd17157;
      {4'd3, 3'd2}: v = 16'd34315;
      {4'd4, 3'd1}: v = 16'd12868;
      {4'd4, 3'd2}: v = 16'd25736;
      {4'd4, 3'd3}: v = 16'd38604;
      {4'd5, 3'd1}: v = 16'd10294;
      {4'd5, 3'd2}: v = 16'd20589;
      {4'd5, 3'd3}: v = 16'd30883;
      {4'd5, 3'd4}: v = 16'd41178;
      {4'd6, 3'd1}: v = 16'd8579;
      {4'd6, 3'd2}: v = 16'd17157;
      {4'd6, 3'd3}: v = 16'd25736;
      {4'd6, 3'd4}: v = 16'd34315;
      {4'd6, 3'd5}: v = 16'd42893;
      {4'd7, 3'd1}: v = 16'd7353;
      {4'd7, 3'd2}: v = 16'd14706;
      {4'd7, 3'd3}: v = 16'd22059;
      {4'd7, 3'd4}: v = 16'd29413;
      {4'd7, 3'd5}: v = 16'd36766;
      {4'd7, 3'd6}: v = 16'd44119;
      {4'd8, 3'd1}: v = 16'd6434;
      {4'd8, 3'd2}: v = 16'd12868;
      {4'd8, 3'd3}: v = 16'd19302;
      {4'd8, 3'd4}: v = 16'd25736;
      {4'd8, 3'd5}: v = 16'd32170;
      {4'd8, 3'd6}: v = 16'd38604;
      {4'd8, 3'd7}: v = 16'd45038;
      default:      v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
    logic signed [POS_W:0] hi;
    logic signed [POS_W:0] lo;
    hi = (POS_W+1)'({1'b0, {(POS_W-1){1'b1}}});
    lo = -hi - (POS_W+1)'(1);
    if (v > hi) return hi[POS_W-1:0];
    if (v < lo) return lo[POS_W-1:0];
    return v[POS_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* hdl/rtpp_fifo.sv */
// Short request queue between the plate sequencer and the trig pipeline.
`default_nettype none
module rtpp_fifo #(
  parameter int DEPTH = 4
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  rtpp_pkg::plate_job_t push_data,
  input  wire                 pop,
  output rtpp_pkg::plate_job_t head,
  output logic                empty,
  output logic                full
);
  import rtpp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  plate_job_t       mem_r [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign head  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? bump(wp_r) : wp_r;
    rp_nxt  = pop ? bump(rp_r) : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end
endmodule
`default_nettype wire

/* hdl/rtpp_front.sv */
// Target intake and plate sequencer: one plate request per cycle into the queue unless it is full.
`default_nettype none
module rtpp_front (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_we,
  input  wire [rtpp_pkg::CNT_W-1:0]       cfg_wdata,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire signed [rtpp_pkg::POS_W-1:0] in_center_x,
  input  wire signed [rtpp_pkg::POS_W-1:0] in_center_y,
  input  wire signed [rtpp_pkg::POS_W-1:0] in_center_z,
  input  wire signed [rtpp_pkg::ANG_W-1:0] in_yaw,
  input  wire [19:0]                      in_base_radius,
  input  wire signed [19:0]               in_radius_offset,
  input  wire signed [19:0]               in_height_offset,
  input  wire                             q_full,
  output logic                            q_push,
  output rtpp_pkg::plate_job_t            q_data
);
  import rtpp_pkg::*;

  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        n_eff, n_r;
  logic                    busy_r, busy_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic signed [POS_W-1:0] cx_r, cy_r, cz_r;
  logic signed [ANG_W-1:0] yaw_r;
  logic [19:0]             rb_r;
  logic signed [19:0]      roff_r, hoff_r;
  logic                    accept, last_issue, alt;
  logic signed [17:0]      sum, wrapped;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
    end else if (cfg_we) begin
      count_r <= cfg_wdata;
    end
  end

  assign n_eff = (count_r > COUNT_MAX) ? COUNT_MAX : count_r;

  assign q_push     = busy_r && !q_full;
  assign last_issue = q_push && ({1'b0, idx_r} == n_r - CNT_W'(1));
  assign in_stall   = busy_r && !last_issue;
  assign accept     = in_valid && !in_stall;

  always_comb begin
    sum = $signed({{2{yaw_r[ANG_W-1]}}, yaw_r}) + $signed({2'b00, plate_step(n_r, idx_r)});
    if (sum > WRAP_TWICE)        wrapped = sum - FOUR_PI_Q13;
    else if (sum > PI_Q13)       wrapped = sum - TWO_PI_Q13;
    else if (sum <= -PI_Q13)     wrapped = sum + TWO_PI_Q13;
    else                         wrapped = sum;

    alt = (n_r == COUNT_ALT) && idx_r[0];

    q_data.cx    = cx_r;
    q_data.cy    = cy_r;
    q_data.z     = alt ? sat_pos($signed({cz_r[POS_W-1], cz_r}) +
                                 (POS_W+1)'(hoff_r)) : cz_r;
    q_data.angle = wrapped[ANG_W-1:0];
    q_data.r     = alt ? $signed({2'b00, rb_r}) + RAD_W'(roff_r)
                       : $signed({2'b00, rb_r});
    q_data.idx   = idx_r;
    q_data.alt   = alt;
    q_data.last  = ({1'b0, idx_r} == n_r - CNT_W'(1));
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (last_issue) begin
      busy_nxt = 1'b0;
    end else if (q_push) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
    if (accept) begin
      busy_nxt = (n_eff != '0);
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      n_r    <= n_eff;
      cx_r   <= in_center_x;
      cy_r   <= in_center_y;
      cz_r   <= in_center_z;
      yaw_r  <= in_yaw;
      rb_r   <= in_base_radius;
      roff_r <= in_radius_offset;
      hoff_r <= in_height_offset;
    end
  end
endmodule
`default_nettype wire

/* hdl/rtpp_back.sv */
// Pipelined CORDIC, radius products and output register.
`default_nettype none
module rtpp_back (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              q_empty,
  input  rtpp_pkg::plate_job_t             q_head,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [rtpp_pkg::IDX_W-1:0]       out_plate_index,
  output logic signed [rtpp_pkg::POS_W-1:0] out_plate_x,
  output logic signed [rtpp_pkg::POS_W-1:0] out_plate_y,
  output logic signed [rtpp_pkg::POS_W-1:0] out_plate_z,
  output logic signed [rtpp_pkg::ANG_W-1:0] out_plate_angle,
  output logic signed [rtpp_pkg::POS_W-1:0] out_dx_dyaw,
  output logic signed [rtpp_pkg::POS_W-1:0] out_dy_dyaw,
  output logic signed [rtpp_pkg::TRIG_W-1:0] out_neg_cos,
  output logic signed [rtpp_pkg::TRIG_W-1:0] out_neg_sin,
  output logic                             out_alternate_plate,
  output logic                             out_last_plate
);
  import rtpp_pkg::*;

  localparam int NS = CORDIC_STEPS;

  logic en;
  logic            v_r  [NS+1];
  logic signed [CW-1:0] x_r [NS+1];
  logic signed [CW-1:0] y_r [NS+1];
  logic signed [CW-1:0] z_r [NS+1];
  logic            flip_r [NS+1];
  plate_job_t      pl_r [NS+1];

  logic signed [CW-1:0] z_in;
  logic            flip_in;

  // whole pipeline advances unless a finished result is held
  assign en    = !out_valid || !out_stall;
  assign q_pop = en && !q_empty;

  always_comb begin
    z_in    = CW'(q_head.angle) <<< 11;
    flip_in = 1'b0;
    if (z_in > HALF_PI_Q24) begin
      z_in    = z_in - PI_Q24;
      flip_in = 1'b1;
    end else if (z_in < -HALF_PI_Q24) begin
      z_in    = z_in + PI_Q24;
      flip_in = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0]    <= !q_empty;
      x_r[0]    <= GAIN_Q24;
      y_r[0]    <= '0;
      z_r[0]    <= z_in;
      flip_r[0] <= flip_in;
      pl_r[0]   <= q_head;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1]    <= v_r[k];
        flip_r[k+1] <= flip_r[k];
        pl_r[k+1]   <= pl_r[k];
        if (z_r[k] >= 0) begin
          x_r[k+1] <= x_r[k] - (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] + (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] - ATAN_Q24[k];
        end else begin
          x_r[k+1] <= x_r[k] + (y_r[k] >>> k);
          y_r[k+1] <= y_r[k] - (x_r[k] >>> k);
          z_r[k+1] <= z_r[k] + ATAN_Q24[k];
        end
      end
    end
  end

  // rounding to Q1.14 with clamp
  function automatic logic signed [TRIG_W-1:0] to_q14(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    t = (v + CW'(512)) >>> 10;
    if (t > CW'(16384))  return TRIG_W'(16384);
    if (t < -CW'(16384)) return -TRIG_W'(16384);
    return t[TRIG_W-1:0];
  endfunction

  logic                    tv_r, mv_r;
  logic signed [TRIG_W-1:0] c_r, s_r, mc_r, ms_r;
  plate_job_t              tpl_r, mpl_r;
  logic signed [CW-1:0]    xf, yf;
  logic signed [RAD_W+TRIG_W-1:0] pc, ps;
  logic signed [POS_W-1:0] rc_r, rs_r;

  assign xf = flip_r[NS] ? -x_r[NS] : x_r[NS];
  assign yf = flip_r[NS] ? -y_r[NS] : y_r[NS];
  assign pc = tpl_r.r * c_r + (RAD_W+TRIG_W)'(8192);
  assign ps = tpl_r.r * s_r + (RAD_W+TRIG_W)'(8192);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r      <= 1'b0;
      mv_r      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      tv_r      <= v_r[NS];
      mv_r      <= tv_r;
      out_valid <= mv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r   <= to_q14(xf);
      s_r   <= to_q14(yf);
      tpl_r <= pl_r[NS];

      rc_r  <= POS_W'(pc >>> 14);
      rs_r  <= POS_W'(ps >>> 14);
      mc_r  <= c_r;
      ms_r  <= s_r;
      mpl_r <= tpl_r;

      out_plate_index     <= mpl_r.idx;
      out_plate_x         <= sat_pos((POS_W+1)'(mpl_r.cx) - (POS_W+1)'(rc_r));
      out_plate_y         <= sat_pos((POS_W+1)'(mpl_r.cy) - (POS_W+1)'(rs_r));
      out_plate_z         <= mpl_r.z;
      out_plate_angle     <= mpl_r.angle;
      out_dx_dyaw         <= rs_r;
      out_dy_dyaw         <= sat_pos(-(POS_W+1)'(rc_r));
      out_neg_cos         <= -mc_r;
      out_neg_sin         <= -ms_r;
      out_alternate_plate <= mpl_r.alt;
      out_last_plate      <= mpl_r.last;
    end
  end
endmodule
`default_nettype wire

/* hdl/rotating_target_plate_positions_core.sv */
// Top level: plate sequencer, request queue and trig/product pipeline.
//
//   channel  dir  handshake          payload
//   in       in   in_valid/in_stall  target centre, yaw, radius, offsets
//   out      out  out_valid/out_stall one plate per request
//   cfg      in   cfg_we             armor_count
//
// One plate per cycle while the queue has room; the input stalls until a target's last plate is queued.
// Pipeline after the entry register: 20 CORDIC stages, rounding, product, output.
// A zero plate count accepts the target without stalling and emits nothing.
// A held result on out freezes the whole pipeline; the queue absorbs QUEUE_DEPTH plates (4 by default).
// Synchronous reset; no clearing pass.
`default_nettype none
module rotating_target_plate_positions_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire [rtpp_pkg::CNT_W-1:0]        cfg_wdata,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire signed [rtpp_pkg::POS_W-1:0] in_center_x,
  input  wire signed [rtpp_pkg::POS_W-1:0] in_center_y,
  input  wire signed [rtpp_pkg::POS_W-1:0] in_center_z,
  input  wire signed [rtpp_pkg::ANG_W-1:0] in_yaw,
  input  wire [19:0]                       in_base_radius,
  input  wire signed [19:0]                in_radius_offset,
  input  wire signed [19:0]                in_height_offset,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [rtpp_pkg::IDX_W-1:0]       out_plate_index,
  output logic signed [rtpp_pkg::POS_W-1:0] out_plate_x,
  output logic signed [rtpp_pkg::POS_W-1:0] out_plate_y,
  output logic signed [rtpp_pkg::POS_W-1:0] out_plate_z,
  output logic signed [rtpp_pkg::ANG_W-1:0] out_plate_angle,
  output logic signed [rtpp_pkg::POS_W-1:0] out_dx_dyaw,
  output logic signed [rtpp_pkg::POS_W-1:0] out_dy_dyaw,
  output logic signed [rtpp_pkg::TRIG_W-1:0] out_neg_cos,
  output logic signed [rtpp_pkg::TRIG_W-1:0] out_neg_sin,
  output logic                             out_alternate_plate,
  output logic                             out_last_plate
);
  import rtpp_pkg::*;

  plate_job_t push_data, head;
  logic       push, pop, empty, full;

  rtpp_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_valid, .in_stall,
    .in_center_x, .in_center_y, .in_center_z, .in_yaw,
    .in_base_radius, .in_radius_offset, .in_height_offset,
    .q_full(full), .q_push(push), .q_data(push_data)
  );

  rtpp_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .push, .push_data, .pop, .head, .empty, .full
  );

  rtpp_back u_back (
    .clk, .rst_n, .q_empty(empty), .q_head(head), .q_pop(pop),
    .out_valid, .out_stall, .out_plate_index, .out_plate_x, .out_plate_y,
    .out_plate_z, .out_plate_angle, .out_dx_dyaw, .out_dy_dyaw,
    .out_neg_cos, .out_neg_sin, .out_alternate_plate, .out_last_plate
  );
endmodule
`default_nettype wire

/* hdl/rtpp_checker.sv */
// Port-level checks for the plate position core, bound to the top level.
`default_nettype none
module rtpp_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_stall,
  input wire [2:0]  out_plate_index,
  input wire [23:0] out_plate_x,
  input wire [15:0] out_plate_angle,
  input wire [15:0] out_neg_cos,
  input wire        out_alternate_plate
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_plate_x))
    else $error("held result changed");

  a_alt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alternate_plate |-> out_plate_index[0] && !out_plate_index[2])
    else $error("alternate flag on even plate");

  a_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_plate_angle) <= 16'sd25736) &&
                  ($signed(out_plate_angle) > -16'sd25736))
    else $error("angle not wrapped");

  a_cos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_neg_cos) <= 16'sd16384) &&
                  ($signed(out_neg_cos) >= -16'sd16384))
    else $error("cosine out of range");
endmodule

bind rotating_target_plate_positions_core rtpp_checker u_rtpp_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_plate_index, .out_plate_x,
  .out_plate_angle, .out_neg_cos, .out_alternate_plate
);
`default_nettype wire
